FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the first-seen table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fstwa_pkg.sv
// Package with the types, codes and constants of the first-seen table.
`default_nettype none

package fstwa_pkg;

    // Field widths.
    localparam int FUNC_W      = 2;
    localparam int ID_W        = 31;
    localparam int TIME_W      = 34;
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_OUT_W = 7;

    // Hours converted to seconds: 14 bits times 3600 fits in 26 bits.
    localparam int SEC_W           = 26;
    localparam int SEC_PER_HOUR    = 3600;
    localparam int ASSUMED_ARRIVAL = 2 * 3600;

    // Default table depth.
    localparam int DEFAULT_TABLE_ENTRIES = 64;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] KICKOFF_CAP_RESET = CFG_W'(48);
    localparam logic [CFG_W-1:0] FRESH_RESET       = CFG_W'(12);
    localparam logic [CFG_W-1:0] KEEP_RESET        = CFG_W'(72);

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_OBSERVE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END_BATCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRUNE     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLASSIFY  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KICKOFF_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP        = 2'd2;

    // Control states of the table sequencer.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fstwa_state_t;

endpackage

`default_nettype wire

FILE: design/fstwa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module fstwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_array_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/first_seen_table_with_aging_top.sv
// Top level of the first-seen table with aging.
`default_nettype none
`include "assert_macros.svh"

// The table holds up to TABLE_ENTRIES item records (valid bit, id, first-seen time) in
// one RAM with a registered read. After reset the block clears the RAM, one entry a cycle,
// and accepts no request during that pass; configuration writes are taken at any time.
// Observe, prune and classify requests scan the whole table through the single read port,
// one entry a cycle; the block takes no new request until the result of the current one
// is loaded into the output register. An end-of-batch request skips the scan. Each
// request yields exactly one result, held in an output register, so the next request is
// accepted while a result still waits to be taken. An observe of a new, finished, scored
// item with a nonzero id inserts into the lowest free entry; a full table drops it.
module first_seen_table_with_aging_top
    import fstwa_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    // Request channel.
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [FUNC_W-1:0]      func,
    input  wire logic [ID_W-1:0]        item_id,
    input  wire logic [TIME_W-1:0]      kickoff_time,
    input  wire logic                   is_finished,
    input  wire logic                   has_result,
    input  wire logic [TIME_W-1:0]      now_time,

    // Result channel.
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [TIME_W-1:0]      seen_time,
    output logic                        recent_flag,
    output logic                        fresh_flag,
    output logic                        inserted,
    output logic                        dropped_full,
    output logic      [COUNT_OUT_W-1:0] record_count
);

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int CW     = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = 1 + ID_W + TIME_W;
    localparam int SUM_W  = TIME_W + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    // Sequencer state.
    fstwa_state_t state_reg;
    fstwa_state_t state_next;

    // Scan address generation and read data tracking.
    logic [AW-1:0] issue_idx_reg;
    logic          issue_done_reg;
    logic          data_vld_reg;
    logic [AW-1:0] data_idx_reg;

    // Configuration registers.
    logic [CFG_W-1:0] kickoff_cap_reg;
    logic [CFG_W-1:0] fresh_hours_reg;
    logic [CFG_W-1:0] keep_hours_reg;

    // Latched request.
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] kickoff_reg;
    logic              finished_reg;
    logic              scored_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SEC_W-1:0]  cap_sec_reg;
    logic [SEC_W-1:0]  fresh_sec_reg;
    logic [SEC_W-1:0]  keep_sec_reg;

    // Compares on the latched request, settled during the scan.
    logic              recent_cmp_reg;
    logic              boot_cmp_reg;
    logic [TIME_W-1:0] boot_time_reg;

    // Scan findings.
    logic              found_reg;
    logic [TIME_W-1:0] found_time_reg;
    logic              free_found_reg;
    logic [AW-1:0]     free_idx_reg;

    // Table bookkeeping.
    logic          bootstrap_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result register.
    logic              out_valid_reg;
    logic [TIME_W-1:0] seen_time_reg;
    logic              recent_flag_reg;
    logic              fresh_flag_reg;
    logic              inserted_reg;
    logic              dropped_full_reg;
    logic [COUNT_OUT_W-1:0] record_count_reg;

    // RAM interface.
    logic              mem_we;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_re;
    logic [WORD_W-1:0] mem_rd_data;

    // Decoded read word.
    logic              rd_valid;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_time;

    // Control and result terms.
    logic              req_accept;
    logic              out_load;
    logic              prune_hit;
    logic              prune_clr;
    logic              entry_match;
    logic              insert_want;
    logic              insert_ok;
    logic              drop_full;
    logic              fresh_cmp;
    logic [TIME_W-1:0] ins_time;
    logic [TIME_W-1:0] seen_next;
    logic              recent_next;
    logic              fresh_next;

    fstwa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (issue_idx_reg),
        .rd_data (mem_rd_data)
    );

    assign rd_valid = mem_rd_data[WORD_W-1];
    assign rd_id    = mem_rd_data[TIME_W +: ID_W];
    assign rd_time  = mem_rd_data[TIME_W-1:0];

    assign cfg_ready  = 1'b1;
    assign req_accept = in_valid && !in_stall;

    // Entry compares on the word that arrives from the RAM, and the fresh compare on the found time.
    assign entry_match = rd_valid && (rd_id == id_reg) && (id_reg != '0);
    assign prune_hit   = data_vld_reg && rd_valid &&
                         (({1'b0, rd_time} + SUM_W'(keep_sec_reg)) < {1'b0, now_reg});
    assign fresh_cmp   = ({1'b0, found_time_reg} + SUM_W'(fresh_sec_reg)) > {1'b0, now_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kickoff_cap_reg <= KICKOFF_CAP_RESET;
            fresh_hours_reg <= FRESH_RESET;
            keep_hours_reg  <= KEEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KICKOFF_CAP: kickoff_cap_reg <= cfg_data;
                CFG_FRESH:       fresh_hours_reg <= cfg_data;
                CFG_KEEP:        keep_hours_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (issue_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == FUNC_END_BATCH) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (data_vld_reg && (data_idx_reg == LAST_IDX))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, RAM access and result loading.
    always_comb
    begin
        in_stall    = 1'b1;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_wr_addr = data_idx_reg;
        mem_wr_data = '0;
        out_load    = 1'b0;
        prune_clr   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = issue_idx_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                mem_re = !issue_done_reg;
                if ((func_reg == FUNC_PRUNE) && prune_hit)
                begin
                    // Drop the record by writing back a cleared word.
                    prune_clr   = 1'b1;
                    mem_we      = 1'b1;
                    mem_wr_addr = data_idx_reg;
                end
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || !out_stall;
                if (out_load && insert_ok)
                begin
                    mem_we      = 1'b1;
                    mem_wr_addr = free_idx_reg;
                    mem_wr_data = {1'b1, id_reg, ins_time};
                end
            end
            default: ;
        endcase
    end

    // Result terms, formed once the scan is complete.
    always_comb
    begin
        insert_want = (func_reg == FUNC_OBSERVE) && !found_reg && finished_reg &&
                      scored_reg && (id_reg != '0);
        insert_ok   = insert_want && free_found_reg;
        drop_full   = insert_want && !free_found_reg;
        ins_time    = (bootstrap_reg && boot_cmp_reg) ? boot_time_reg : now_reg;
        seen_next   = '0;
        recent_next = 1'b0;
        fresh_next  = 1'b0;
        case (func_reg)
            FUNC_OBSERVE:
            begin
                if (found_reg)
                begin
                    seen_next = found_time_reg;
                end
                else if (insert_ok)
                begin
                    seen_next = ins_time;
                end
            end
            FUNC_CLASSIFY:
            begin
                if (found_reg)
                begin
                    seen_next = found_time_reg;
                end
                recent_next = finished_reg && scored_reg && recent_cmp_reg;
                fresh_next  = recent_next && found_reg && fresh_cmp;
            end
            default: ;
        endcase
    end

    // Record count after this cycle's insert or prune.
    always_comb
    begin
        count_next = count_reg;
        if (prune_clr)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (out_load && insert_ok)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b0;
            data_vld_reg   <= 1'b0;
            bootstrap_reg  <= 1'b1;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            data_vld_reg <= mem_re;
            count_reg    <= count_next;

            // Address counter for the clearing pass and the scans.
            case (state_reg)
                ST_CLEAR:
                begin
                    issue_idx_reg <= (issue_idx_reg == LAST_IDX) ? '0 : issue_idx_reg + 1'b1;
                end
                ST_SCAN:
                begin
                    if (!issue_done_reg)
                    begin
                        if (issue_idx_reg == LAST_IDX)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    issue_idx_reg  <= '0;
                    issue_done_reg <= 1'b0;
                end
            endcase

            // First matching record and lowest free entry.
            if (req_accept)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && data_vld_reg)
            begin
                if (!found_reg && entry_match)
                begin
                    found_reg <= 1'b1;
                end
                if (!free_found_reg && !rd_valid)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (out_load && (func_reg == FUNC_END_BATCH))
            begin
                bootstrap_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched request, scan data and result.
    always_ff @(posedge clk)
    begin
        data_idx_reg <= issue_idx_reg;

        if (req_accept)
        begin
            func_reg      <= func;
            id_reg        <= item_id;
            kickoff_reg   <= kickoff_time;
            finished_reg  <= is_finished;
            scored_reg    <= has_result;
            now_reg       <= now_time;
            cap_sec_reg   <= SEC_W'(kickoff_cap_reg) * SEC_W'(SEC_PER_HOUR);
            fresh_sec_reg <= SEC_W'(fresh_hours_reg) * SEC_W'(SEC_PER_HOUR);
            keep_sec_reg  <= SEC_W'(keep_hours_reg) * SEC_W'(SEC_PER_HOUR);
        end

        // Kickoff compares depend only on the latched request.
        recent_cmp_reg <= ({1'b0, kickoff_reg} + SUM_W'(cap_sec_reg)) >= {1'b0, now_reg};
        boot_cmp_reg   <= ({1'b0, kickoff_reg} + SUM_W'(ASSUMED_ARRIVAL)) < {1'b0, now_reg};
        boot_time_reg  <= kickoff_reg + TIME_W'(ASSUMED_ARRIVAL);

        if ((state_reg == ST_SCAN) && data_vld_reg)
        begin
            if (!found_reg && entry_match)
            begin
                found_time_reg <= rd_time;
            end
            if (!free_found_reg && !rd_valid)
            begin
                free_idx_reg <= data_idx_reg;
            end
        end

        if (out_load)
        begin
            seen_time_reg    <= seen_next;
            recent_flag_reg  <= recent_next;
            fresh_flag_reg   <= fresh_next;
            inserted_reg     <= insert_ok;
            dropped_full_reg <= drop_full;
            record_count_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign seen_time    = seen_time_reg;
    assign recent_flag  = recent_flag_reg;
    assign fresh_flag   = fresh_flag_reg;
    assign inserted     = inserted_reg;
    assign dropped_full = dropped_full_reg;
    assign record_count = record_count_reg;

    // The count never exceeds the table depth.
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_ENTRIES), "record count above depth")
    // A write-back during a scan never hits the entry being read.
    `ASSERT_IMPL(a_no_rw_overlap, mem_we && mem_re, mem_wr_addr != issue_idx_reg, "read and write on one entry")
    // An insert raises the count by exactly one.
    `ASSERT_NEXT(a_insert_count, out_load && insert_ok, count_reg == CW'($past(count_reg) + 1'b1), "insert did not count")
    // A result never reports both an insert and a drop, and fresh implies recent.
    `ASSERT_IMPL(a_result_consistent, out_valid_reg, !(inserted_reg && dropped_full_reg) && (!fresh_flag_reg || recent_flag_reg), "inconsistent result flags")

endmodule

`default_nettype wire

FILE: tb/sv/tb_first_seen_table_with_aging_top.sv
// Testbench for the first-seen table: directed and random requests checked against a shadow table.
`timescale 1ns / 1ps

module tb_first_seen_table_with_aging_top;
    import fstwa_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int TABLE_DEPTH     = DEFAULT_TABLE_ENTRIES;
    localparam int POOL_SIZE       = 96;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_SHOWN       = 10;

    // One request as it is presented on the request channel.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   item_id;
        logic [TIME_W-1:0] kickoff_time;
        logic              is_finished;
        logic              has_result;
        logic [TIME_W-1:0] now_time;
    } seen_request_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [TIME_W-1:0]      seen;
        logic                   recent;
        logic                   fresh;
        logic                   inserted;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] records;
    } seen_report_t;

    // Shadow copy of the table and settings, plus the results still awaited.
    class seen_table_shadow;
        logic [ID_W-1:0]   id_at[TABLE_DEPTH];
        logic [TIME_W-1:0] seen_at[TABLE_DEPTH];
        bit                in_use[TABLE_DEPTH];
        bit                bootstrap;
        int unsigned       records;
        logic [CFG_W-1:0]  cap_h;
        logic [CFG_W-1:0]  fresh_h;
        logic [CFG_W-1:0]  keep_h;
        seen_report_t      awaited_reports[$];
        int unsigned       results_checked;
        int unsigned       bad_reports;

        function new();
            cap_h     = KICKOFF_CAP_RESET;
            fresh_h   = FRESH_RESET;
            keep_h    = KEEP_RESET;
            bootstrap = 1'b1;
            records   = 0;
        endfunction

        function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_KICKOFF_CAP: cap_h = value;
                CFG_FRESH:       fresh_h = value;
                CFG_KEEP:        keep_h = value;
                default:         ;
            endcase
        endfunction

        // Entry holding this id, or -1; id zero never matches.
        function int locate(logic [ID_W-1:0] id);
            if (id == '0)
                return -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (in_use[i] && id_at[i] == id)
                    return i;
            return -1;
        endfunction

        // Update the shadow table for an accepted request and queue its result.
        function void note_request(seen_request_t r);
            seen_report_t    rep;
            int              hit;
            int              slot;
            longint unsigned kick;
            longint unsigned now;
            longint unsigned span;

            rep  = '0;
            kick = r.kickoff_time;
            now  = r.now_time;
            case (r.func)
                FUNC_OBSERVE:
                begin
                    hit = locate(r.item_id);
                    if (hit >= 0)
                    begin
                        rep.seen = seen_at[hit];
                    end
                    else if (r.is_finished && r.has_result && r.item_id != '0)
                    begin
                        // The lowest free entry takes the new record.
                        slot = -1;
                        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                            if (!in_use[i])
                                slot = i;
                        if (slot < 0)
                        begin
                            rep.dropped = 1'b1;
                        end
                        else
                        begin
                            rep.seen = r.now_time;
                            if (bootstrap && kick + ASSUMED_ARRIVAL < now)
                                rep.seen = TIME_W'(kick + ASSUMED_ARRIVAL);
                            id_at[slot]   = r.item_id;
                            seen_at[slot] = rep.seen;
                            in_use[slot]  = 1'b1;
                            records++;
                            rep.inserted = 1'b1;
                        end
                    end
                end
                FUNC_END_BATCH:
                begin
                    bootstrap = 1'b0;
                end
                FUNC_PRUNE:
                begin
                    span = 64'(keep_h) * SEC_PER_HOUR;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (in_use[i] && 64'(seen_at[i]) + span < now)
                        begin
                            in_use[i] = 1'b0;
                            records--;
                        end
                end
                default:
                begin
                    hit = locate(r.item_id);
                    if (hit >= 0)
                        rep.seen = seen_at[hit];
                    span = 64'(cap_h) * SEC_PER_HOUR;
                    if (r.is_finished && r.has_result && kick + span >= now)
                    begin
                        rep.recent = 1'b1;
                        span = 64'(fresh_h) * SEC_PER_HOUR;
                        if (hit >= 0 && 64'(rep.seen) + span > now)
                            rep.fresh = 1'b1;
                    end
                end
            endcase
            rep.records = COUNT_OUT_W'(records);
            awaited_reports.insert(awaited_reports.size(), rep);
        endfunction

        // Compare one accepted result with the oldest awaited one.
        function void check_report(seen_report_t got);
            seen_report_t want;

            results_checked++;
            if (awaited_reports.size() == 0)
            begin
                bad_reports++;
                if (bad_reports <= MAX_SHOWN)
                    $display("Result %0d arrived with no request outstanding", results_checked);
                return;
            end
            want = awaited_reports.pop_front();
            if (got.seen !== want.seen || got.recent !== want.recent
                    || got.fresh !== want.fresh || got.inserted !== want.inserted
                    || got.dropped !== want.dropped || got.records !== want.records)
            begin
                bad_reports++;
                if (bad_reports <= MAX_SHOWN)
                    $display("Result %0d mismatch (expected/actual): seen_time %0d/%0d %s",
                             results_checked, want.seen, got.seen,
                             $sformatf("recent %0b/%0b fresh %0b/%0b inserted %0b/%0b %s",
                                       want.recent, got.recent, want.fresh, got.fresh,
                                       want.inserted, got.inserted,
                                       $sformatf("dropped %0b/%0b count %0d/%0d",
                                                 want.dropped, got.dropped,
                                                 want.records, got.records)));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [FUNC_W-1:0]      func;
    logic [ID_W-1:0]        item_id;
    logic [TIME_W-1:0]      kickoff_time;
    logic                   is_finished;
    logic                   has_result;
    logic [TIME_W-1:0]      now_time;
    logic                   out_valid;
    logic                   out_stall;
    logic [TIME_W-1:0]      seen_time;
    logic                   recent_flag;
    logic                   fresh_flag;
    logic                   inserted;
    logic                   dropped_full;
    logic [COUNT_OUT_W-1:0] record_count;

    seen_table_shadow  tracker;
    logic [ID_W-1:0]   id_pool[POOL_SIZE];
    logic [TIME_W-1:0] clock_now;
    int unsigned       observe_pct = 50;
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    int unsigned       quiet_cycles = 0;

    first_seen_table_with_aging_top #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) u_top (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result checking and the watchdog on handshake progress.
    always @(posedge clk)
    begin : result_check
        seen_report_t got;

        if (rst_n === 1'b1)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{seen: seen_time, recent: recent_flag, fresh: fresh_flag,
                        inserted: inserted, dropped: dropped_full, records: record_count};
                tracker.check_report(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: a random stall before each result, none in steady phases.
    initial
    begin : result_sink
        int hold;

        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_steady ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Any 34-bit time, with the two extremes drawn often.
    function automatic logic [TIME_W-1:0] any_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic seen_request_t compose_request(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
            logic [TIME_W-1:0] kick, logic fin, logic scored, logic [TIME_W-1:0] now);
        seen_request_t r;

        r.func         = f;
        r.item_id      = id;
        r.kickoff_time = kick;
        r.is_finished  = fin;
        r.has_result   = scored;
        r.now_time     = now;
        return r;
    endfunction

    // Setting for one register: all zero first, then all maximum, then mixed.
    function automatic logic [CFG_W-1:0] pick_setting(int phase);
        if (phase == 0)
            return '0;
        if (phase <= 2)
            return '1;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(1, 8));
            5:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(9, 120));
        endcase
    endfunction

    // Random request on a running clock, steered toward the comparison edges.
    function automatic seen_request_t random_request();
        seen_request_t   r;
        int unsigned     pick;
        int              hit;
        int              slot;
        longint unsigned cap_s;
        longint unsigned fresh_s;
        longint unsigned keep_s;

        cap_s   = 64'(tracker.cap_h) * SEC_PER_HOUR;
        fresh_s = 64'(tracker.fresh_h) * SEC_PER_HOUR;
        keep_s  = 64'(tracker.keep_h) * SEC_PER_HOUR;

        pick = $urandom_range(0, 99);
        if (pick < observe_pct)
            r.func = FUNC_OBSERVE;
        else if (pick < observe_pct + (100 - observe_pct) * 2 / 3)
            r.func = FUNC_CLASSIFY;
        else if (pick < 97)
            r.func = FUNC_PRUNE;
        else
            r.func = FUNC_END_BATCH;

        // Mostly ids from a pool larger than the table, so it fills and repeats.
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.item_id = '0;
        else if (pick < 84)
            r.item_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            r.item_id = ID_W'($urandom);

        clock_now  = clock_now + TIME_W'($urandom_range(0, 7200));
        r.now_time = ($urandom_range(0, 15) == 0) ? any_time() : clock_now;

        // Kickoff around the recent cap, sometimes exactly on it or in the future.
        pick = $urandom_range(0, 19);
        if (pick < 2)
            r.kickoff_time = any_time();
        else if (pick < 5)
            r.kickoff_time = r.now_time - TIME_W'(cap_s) - TIME_W'($urandom_range(0, 1));
        else if (pick < 7)
            r.kickoff_time = r.now_time + TIME_W'($urandom_range(0, 20000));
        else
            r.kickoff_time = r.now_time
                - TIME_W'($urandom_range(0, 32'(2 * cap_s + ASSUMED_ARRIVAL)));
        r.is_finished = ($urandom_range(0, 99) < 88);
        r.has_result  = ($urandom_range(0, 99) < 88);

        // Classify right at the end of the fresh window of a stored record.
        if (r.func == FUNC_CLASSIFY && $urandom_range(0, 4) == 0)
        begin
            hit = tracker.locate(r.item_id);
            if (hit >= 0)
            begin
                r.now_time     = tracker.seen_at[hit] + TIME_W'(fresh_s)
                                 - TIME_W'($urandom_range(0, 1));
                r.kickoff_time = r.now_time;
                r.is_finished  = 1'b1;
                r.has_result   = 1'b1;
            end
        end

        // Prune right at the keep limit of a stored record.
        if (r.func == FUNC_PRUNE && $urandom_range(0, 3) == 0)
        begin
            slot = $urandom_range(0, TABLE_DEPTH - 1);
            if (tracker.in_use[slot])
                r.now_time = tracker.seen_at[slot] + TIME_W'(keep_s)
                             + TIME_W'($urandom_range(0, 1));
        end
        return r;
    endfunction

    // Present one request after a random gap and wait until it is taken.
    task automatic issue_request(input seen_request_t r);
        int gap;

        gap = tx_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= r.func;
        item_id      <= r.item_id;
        kickoff_time <= r.kickoff_time;
        is_finished  <= r.is_finished;
        has_result   <= r.has_result;
        now_time     <= r.now_time;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(r);
    endtask

    // Stop sending and wait until every awaited result has been taken.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.awaited_reports.size() != 0);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.apply_setting(idx, value);
    endtask

    initial
    begin : stimulus
        int                phase;
        int                n;
        logic [TIME_W-1:0] t0;

        tracker = new();
        t0      = TIME_W'(64'd1_700_000_000);

        // All inputs known from time zero; reset held low, then released.
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        func         <= FUNC_OBSERVE;
        item_id      <= '0;
        kickoff_time <= '0;
        is_finished  <= 1'b0;
        has_result   <= 1'b0;
        now_time     <= '0;
        id_pool[0] = '1;
        for (int i = 1; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom_range(1, 32'h7FFF_FFFF));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings, starting in bootstrap.
        issue_request(compose_request(FUNC_CLASSIFY, 31'd5, t0 - 34'd1000, 1'b1, 1'b1, t0));
        issue_request(compose_request(FUNC_OBSERVE, '0, t0, 1'b1, 1'b1, t0));
        issue_request(compose_request(FUNC_OBSERVE, 31'd5, t0, 1'b0, 1'b1, t0));
        issue_request(compose_request(FUNC_OBSERVE, 31'd5, t0, 1'b1, 1'b0, t0));
        // Bootstrap: an old kickoff sets the time, a recent one leaves it at now.
        issue_request(compose_request(FUNC_OBSERVE, 31'd5, t0 - 34'd100000, 1'b1, 1'b1, t0));
        issue_request(compose_request(FUNC_OBSERVE, 31'd6, t0 - 34'd3600, 1'b1, 1'b1, t0));
        // A record stored at time zero still exists and can be fresh.
        issue_request(compose_request(FUNC_OBSERVE, '1, '0, 1'b1, 1'b1, '0));
        issue_request(compose_request(FUNC_OBSERVE, 31'd5, t0, 1'b1, 1'b1, t0 + 34'd10));
        issue_request(compose_request(FUNC_CLASSIFY, '1, '0, 1'b1, 1'b1, '0));
        issue_request(compose_request(FUNC_CLASSIFY, '0, t0, 1'b1, 1'b1, t0));
        // Kickoff exactly at the cap and one second past it.
        issue_request(compose_request(FUNC_CLASSIFY, 31'd5, t0 - 34'd172800, 1'b1, 1'b1, t0));
        issue_request(compose_request(FUNC_CLASSIFY, 31'd6, t0 - 34'd172801, 1'b1, 1'b1, t0));
        // First seen after now, then exactly at the end of the fresh window.
        issue_request(compose_request(FUNC_CLASSIFY, 31'd6, t0, 1'b1, 1'b1, t0 - 34'd43200));
        issue_request(compose_request(FUNC_CLASSIFY, 31'd6, t0 + 34'd43200, 1'b1, 1'b1,
                                      t0 + 34'd43200));
        issue_request(compose_request(FUNC_END_BATCH, '0, '0, 1'b0, 1'b0, '0));
        issue_request(compose_request(FUNC_OBSERVE, 31'h2AAA_AAAA, '1, 1'b1, 1'b1, '1));
        issue_request(compose_request(FUNC_OBSERVE, 31'h5555_5555, '0, 1'b1, 1'b1, t0));
        issue_request(compose_request(FUNC_CLASSIFY, 31'h2AAA_AAAA, '1, 1'b1, 1'b1, '1));
        // Prune with a cutoff before time zero, then at and past the keep limit.
        issue_request(compose_request(FUNC_PRUNE, '0, '0, 1'b0, 1'b0, '0));
        issue_request(compose_request(FUNC_PRUNE, '0, '0, 1'b0, 1'b0, t0 + 34'd259200));
        issue_request(compose_request(FUNC_PRUNE, '0, '0, 1'b0, 1'b0, t0 + 34'd259201));
        issue_request(compose_request(FUNC_OBSERVE, 31'd5, t0, 1'b1, 1'b1, t0 + 34'd259201));
        issue_request(compose_request(FUNC_CLASSIFY, 31'd5, t0, 1'b0, 1'b1, t0 + 34'd259201));
        issue_request(compose_request(FUNC_PRUNE, '0, '0, 1'b1, 1'b1, '1));

        // Random phases, each under new settings written while the block is idle.
        for (phase = 0; phase < PHASES; phase++)
        begin
            hold_until_drained();
            write_setting(CFG_KICKOFF_CAP, pick_setting(phase));
            write_setting(CFG_FRESH, pick_setting(phase));
            write_setting(CFG_KEEP, pick_setting(phase));
            cfg_valid <= 1'b0;
            observe_pct = (phase == 1 || phase == 2 || $urandom_range(0, 3) == 0) ? 80 : 50;
            tx_steady   = ($urandom_range(0, 3) == 0);
            rx_steady   = ($urandom_range(0, 3) == 0);
            clock_now   = any_time();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                issue_request(random_request());
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.bad_reports == 0 && tracker.awaited_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
